// File: sv/rlos_pkg.sv
// Shared constants, types and structs for the one-wire RGB LED serializer.
`default_nettype none
package rlos_pkg;

    localparam int QUEUE_DEPTH_DEF    = 8;
    localparam int BITS_PER_PIXEL_DEF = 24;

    localparam int PIXEL_W = 24;
    localparam int DIV_W   = 16;
    localparam int PHASE_W = 4;

    // Slot layout of one bit: low, then high, then data.
    localparam logic [PHASE_W-1:0] SLOTS_PER_BIT = 4'd10;
    localparam logic [PHASE_W-1:0] LOW_SLOTS     = 4'd3;
    localparam logic [PHASE_W-1:0] HIGH_SLOT_END = 4'd5;

    // Register select, taken from paddr[2].
    localparam logic REG_SLOT_DIVIDER = 1'b0;
    localparam logic REG_LATCH_SLOTS  = 1'b1;

    localparam logic [DIV_W-1:0] SLOT_DIVIDER_RST = 16'd16;
    localparam logic [DIV_W-1:0] LATCH_SLOTS_RST  = 16'd480;

    typedef struct packed {
        logic               marker;
        logic [PIXEL_W-1:0] pixel;
    } queue_entry_t;

    typedef struct packed {
        logic pop;
        logic level;
        logic active;
    } timer_status_t;

endpackage
`default_nettype wire

// File: sv/rgb_led_one_wire_serializer_top.sv
// Top level of the one-wire RGB LED serializer: byte packing, queue control, output beat.
`default_nettype none
// One beat in, one beat out, every cycle: each input beat (a colour byte or a
// clock tick) is answered in the next cycle by a result beat in the output
// register, and a new beat is taken in the same cycle as the previous result
// leaves, so the sustained rate is one beat per clock; only out_stall holds
// the input back. Colour bytes are packed green, red, blue into 24-bit pixels
// and kept in a ring of QUEUE_DEPTH entries held in a synchronous RAM with a
// registered read. The RAM is read at the next head address every cycle, with
// a write bypass, so the head entry is always ready when an idle tick starts
// it at once. A byte that closes both a pixel and a frame pushes two entries;
// the latch marker is written in the next cycle through a one-entry write
// buffer, which always finds the write port free. The RAM is not cleared
// after reset; only counted entries are ever read. Ticks drive the line at
// ten slots per bit (3 low, 2 high, 5 data), slot_divider ticks per slot
// (0 acts as 1), and a frame ends with latch_slots low slots once its last
// bit is out. Registers: slot_divider at 0x0, latch_slots at 0x4.
module rgb_led_one_wire_serializer_top #(
    parameter int QUEUE_DEPTH    = rlos_pkg::QUEUE_DEPTH_DEF,
    parameter int BITS_PER_PIXEL = rlos_pkg::BITS_PER_PIXEL_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    // input channel
    input  wire         in_valid,
    output logic        in_stall,
    input  wire         req_type,
    input  wire  [7:0]  byte_value,
    input  wire         frame_end,
    // output channel
    output logic        out_valid,
    input  wire         out_stall,
    output logic        accepted,
    output logic        line_level,
    output logic        busy_res,
    // configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rlos_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    // configuration
    logic [DIV_W-1:0] slot_divider_reg;
    logic [DIV_W-1:0] latch_slots_reg;
    logic             cfg_write;

    // byte packing and queue control
    logic [15:0]      partial_reg, partial_next;
    logic [1:0]       held_reg, held_next;
    logic             has_pixel_reg, has_pixel_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [PTR_W-1:0] pend_addr_reg, pend_addr_next;

    // output beat
    logic out_valid_reg;
    logic accepted_reg;
    logic line_level_reg;
    logic busy_reg;

    logic             in_fire;
    logic             tick;
    logic             byte_req;
    logic             completes;
    logic             frame_pixel;
    logic             push_marker;
    logic [1:0]       need;
    logic [CNT_W-1:0] room;
    logic             byte_ok;

    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    queue_entry_t     wr_data;
    queue_entry_t     head_entry;
    timer_status_t    tstat;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_divider_reg <= SLOT_DIVIDER_RST;
            latch_slots_reg  <= LATCH_SLOTS_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_SLOT_DIVIDER: slot_divider_reg <= pwdata[DIV_W-1:0];
                REG_LATCH_SLOTS:  latch_slots_reg  <= pwdata[DIV_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SLOT_DIVIDER: prdata = 32'(slot_divider_reg);
            REG_LATCH_SLOTS:  prdata = 32'(latch_slots_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;
    assign tick     = in_fire && req_type;
    assign byte_req = in_fire && !req_type;

    // ---------------- byte packing ----------------
    // Two bytes already held means this byte completes a pixel.
    assign completes   = held_reg[1];
    assign frame_pixel = has_pixel_reg || completes;
    assign push_marker = frame_end && frame_pixel;
    assign need        = {1'b0, completes} + {1'b0, push_marker};
    assign room        = CNT_W'(QUEUE_DEPTH) - count_reg;
    assign byte_ok     = byte_req && (CNT_W'(need) <= room);

    always_comb
    begin
        partial_next    = partial_reg;
        held_next       = held_reg;
        has_pixel_next  = has_pixel_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        wr_en           = 1'b0;
        wr_addr         = tail_reg;
        wr_data         = '{marker: 1'b0, pixel: {partial_reg, byte_value}};

        if (byte_ok)
        begin
            if (completes)
            begin
                wr_en          = 1'b1;
                tail_next      = ptr_inc(tail_reg);
                has_pixel_next = 1'b1;
                partial_next   = '0;
                held_next      = '0;
            end
            else
            begin
                partial_next = {partial_reg[7:0], byte_value};
                held_next    = held_reg + 2'd1;
            end

            if (frame_end)
            begin
                if (frame_pixel)
                begin
                    if (completes)
                    begin
                        // marker goes in behind the pixel, next cycle
                        pend_valid_next = 1'b1;
                        pend_addr_next  = tail_next;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_data = '{marker: 1'b1, pixel: '0};
                    end
                    tail_next = ptr_inc(tail_next);
                end
                partial_next   = '0;
                held_next      = '0;
                has_pixel_next = 1'b0;
            end
            count_next = count_reg + CNT_W'(need);
        end

        if (tstat.pop)
        begin
            head_next  = ptr_inc(head_reg);
            count_next = count_reg - CNT_W'(1);
        end

        // buffered marker; the port is never wanted twice in one cycle
        if (pend_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg;
            wr_data = '{marker: 1'b1, pixel: '0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg    <= '0;
            held_reg       <= '0;
            has_pixel_reg  <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_addr_reg  <= '0;
        end
        else
        begin
            partial_reg    <= partial_next;
            held_reg       <= held_next;
            has_pixel_reg  <= has_pixel_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            pend_addr_reg  <= pend_addr_next;
        end
    end

    // ---------------- queue memory ----------------
    // Read at the next head so the head word is registered and ready.
    rlos_queue_ram #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (head_next),
        .rd_data (head_entry)
    );

    // ---------------- line timing ----------------
    rlos_line_timer #(
        .BITS_PER_PIXEL (BITS_PER_PIXEL)
    ) u_timer (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (tick),
        .queue_empty  (count_reg == '0),
        .head_entry   (head_entry),
        .slot_divider (slot_divider_reg),
        .latch_slots  (latch_slots_reg),
        .status       (tstat)
    );

    // ---------------- output beat ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            accepted_reg   <= byte_ok;
            line_level_reg <= tstat.level;
            busy_reg       <= (count_next != '0) || tstat.active;
        end
    end

    assign out_valid  = out_valid_reg;
    assign accepted   = accepted_reg;
    assign line_level = line_level_reg;
    assign busy_res   = busy_reg;

endmodule
`default_nettype wire

// File: sv/rlos_queue_ram.sv
// Pixel queue memory: one write port, one registered read port with write bypass.
`default_nettype none
module rlos_queue_ram #(
    parameter int DEPTH = rlos_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                        clk,
    input  wire                        wr_en,
    input  wire  [$clog2(DEPTH)-1:0]   wr_addr,
    input  rlos_pkg::queue_entry_t     wr_data,
    input  wire  [$clog2(DEPTH)-1:0]   rd_addr,
    output rlos_pkg::queue_entry_t     rd_data
);
    import rlos_pkg::*;

    queue_entry_t queue_mem [DEPTH];
    queue_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            queue_mem[wr_addr] <= wr_data;
        end
    end

    // Same-address write in this cycle wins over the stored word.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= queue_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: sv/rlos_line_timer.sv
// Line timing: slot divider, bit/slot counters, pixel shifter and latch counter.
`default_nettype none
module rlos_line_timer #(
    parameter int BITS_PER_PIXEL = rlos_pkg::BITS_PER_PIXEL_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          tick,
    input  wire                          queue_empty,
    input  rlos_pkg::queue_entry_t       head_entry,
    input  wire  [rlos_pkg::DIV_W-1:0]   slot_divider,
    input  wire  [rlos_pkg::DIV_W-1:0]   latch_slots,
    output rlos_pkg::timer_status_t      status
);
    import rlos_pkg::*;

    localparam int BIT_W = $clog2(BITS_PER_PIXEL);
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(BITS_PER_PIXEL - 1);

    logic                      sending_reg, sending_next;
    logic [BITS_PER_PIXEL-1:0] shift_reg, shift_next;
    logic [BIT_W-1:0]          bit_index_reg, bit_index_next;
    logic [PHASE_W-1:0]        phase_reg, phase_next;
    logic [DIV_W-1:0]          div_count_reg, div_count_next;
    logic [DIV_W-1:0]          latch_count_reg, latch_count_next;

    logic                      e_sending;
    logic [BITS_PER_PIXEL-1:0] e_shift;
    logic [BIT_W-1:0]          e_bit;
    logic [PHASE_W-1:0]        e_phase;
    logic [DIV_W-1:0]          e_div;
    logic [DIV_W-1:0]          e_latch;
    logic                      run;
    logic                      pop;
    logic                      level;
    logic [DIV_W-1:0]          div_eff;
    logic [DIV_W:0]            div_inc;

    assign div_eff = (slot_divider == '0) ? DIV_W'(1) : slot_divider;

    always_comb
    begin
        // state seen by this tick, after a possible load of the head entry
        e_sending = sending_reg;
        e_shift   = shift_reg;
        e_bit     = bit_index_reg;
        e_phase   = phase_reg;
        e_div     = div_count_reg;
        e_latch   = latch_count_reg;
        run       = tick;
        pop       = 1'b0;

        if (tick && !sending_reg && (latch_count_reg == '0))
        begin
            if (queue_empty)
            begin
                run = 1'b0;
            end
            else
            begin
                pop     = 1'b1;
                e_div   = '0;
                e_phase = '0;
                e_bit   = '0;
                if (head_entry.marker)
                begin
                    e_latch = latch_slots;
                    if (latch_slots == '0)
                    begin
                        run = 1'b0;
                    end
                end
                else
                begin
                    e_shift   = BITS_PER_PIXEL'(head_entry.pixel) << (BITS_PER_PIXEL - PIXEL_W);
                    e_sending = 1'b1;
                end
            end
        end

        if (!e_sending)
        begin
            level = 1'b0;
        end
        else if (e_phase < LOW_SLOTS)
        begin
            level = 1'b0;
        end
        else if (e_phase < HIGH_SLOT_END)
        begin
            level = 1'b1;
        end
        else
        begin
            level = e_shift[BITS_PER_PIXEL-1];
        end

        sending_next     = e_sending;
        shift_next       = e_shift;
        bit_index_next   = e_bit;
        phase_next       = e_phase;
        div_count_next   = e_div;
        latch_count_next = e_latch;
        div_inc          = {1'b0, e_div} + (DIV_W+1)'(1);

        if (run)
        begin
            if (div_inc >= {1'b0, div_eff})
            begin
                div_count_next = '0;
                if (e_sending)
                begin
                    if (e_phase == SLOTS_PER_BIT - PHASE_W'(1))
                    begin
                        phase_next = '0;
                        shift_next = e_shift << 1;
                        if (e_bit == LAST_BIT)
                        begin
                            bit_index_next = '0;
                            sending_next   = 1'b0;
                        end
                        else
                        begin
                            bit_index_next = e_bit + BIT_W'(1);
                        end
                    end
                    else
                    begin
                        phase_next = e_phase + PHASE_W'(1);
                    end
                end
                else if (e_latch != '0)
                begin
                    latch_count_next = e_latch - DIV_W'(1);
                end
            end
            else
            begin
                div_count_next = div_inc[DIV_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg     <= 1'b0;
            shift_reg       <= '0;
            bit_index_reg   <= '0;
            phase_reg       <= '0;
            div_count_reg   <= '0;
            latch_count_reg <= '0;
        end
        else
        begin
            sending_reg     <= sending_next;
            shift_reg       <= shift_next;
            bit_index_reg   <= bit_index_next;
            phase_reg       <= phase_next;
            div_count_reg   <= div_count_next;
            latch_count_reg <= latch_count_next;
        end
    end

    assign status.pop    = pop;
    assign status.level  = level;
    assign status.active = sending_next || (latch_count_next != '0);

endmodule
`default_nettype wire

// File: sv/rlos_checker.sv
// Port-level checks for the serializer top, bound to every instance.
`default_nettype none
module rlos_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       in_valid,
    input wire       in_stall,
    input wire       req_type,
    input wire       out_valid,
    input wire       out_stall,
    input wire       accepted,
    input wire       line_level,
    input wire       busy_res
);

    // every accepted beat leaves a result in the output register
    a_beat_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted beat produced no result");

    // a tick never reports a byte as taken
    a_tick_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && req_type) |=> !accepted)
        else $error("tick result shows accepted");

    // input is held back only by a waiting result
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(accepted) && $stable(line_level) && $stable(busy_res)))
        else $error("stalled result changed");

endmodule

bind rgb_led_one_wire_serializer_top rlos_checker u_rlos_checker (.*);
`default_nettype wire

// File: tb/sv/rgb_led_one_wire_serializer_top_tb.sv
// Self-checking testbench for the one-wire RGB LED serializer top level.
`default_nettype none
module rgb_led_one_wire_serializer_top_tb;
    import rlos_pkg::*;

    localparam int FIFO_DEPTH = QUEUE_DEPTH_DEF;
    localparam int PIX_BITS   = BITS_PER_PIXEL_DEF;

    // Receiver pressure: one long hold-off, and a window with no random stall.
    localparam int unsigned HOLD_AT     = 150;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned RX_CALM_LO  = 350;
    localparam int unsigned RX_CALM_HI  = 550;
    // Sender window with no idle cycles.
    localparam int unsigned TX_CALM_LO  = 600;
    localparam int unsigned TX_CALM_HI  = 800;
    localparam int unsigned IDLE_PCT    = 12;
    localparam int unsigned STUCK_LIMIT = 3000;
    localparam int unsigned MAX_REPORTS = 10;

    typedef enum logic {
        REQ_BYTE = 1'b0,
        REQ_TICK = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic accepted;
        logic line;
        logic busy;
    } led_result_t;

    typedef struct packed {
        req_kind_t   kind;
        logic [7:0]  val;
        logic        fe;
        logic        typed;   // want below is fixed by hand
        led_result_t want;
    } stim_row_t;

    typedef struct packed {
        logic [15:0] div;
        logic [15:0] latch;
        int unsigned n;
        int unsigned byte_pct;
    } phase_t;

    // Directed beats. Typed rows: idle reset state, frame end with no pixel,
    // the first pixel plus latch marker, the two queue-full refusals and a last tick.
    localparam int N_ROWS = 26;
    localparam stim_row_t DIR_ROWS [N_ROWS] = '{
        '{REQ_TICK, 8'h00, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0}},
        '{REQ_BYTE, 8'h00, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0}},
        '{REQ_BYTE, 8'hFF, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b0}},
        '{REQ_BYTE, 8'h80, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b0}},
        '{REQ_BYTE, 8'h01, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b1}},
        '{REQ_BYTE, 8'hAA, 1'b0, 1'b0, '0},
        '{REQ_BYTE, 8'h55, 1'b0, 1'b0, '0},
        '{REQ_BYTE, 8'h0F, 1'b0, 1'b0, '0},
        '{REQ_BYTE, 8'hF0, 1'b0, 1'b0, '0},
        '{REQ_BYTE, 8'h33, 1'b0, 1'b0, '0},
        '{REQ_BYTE, 8'hCC, 1'b0, 1'b0, '0},
        '{REQ_BYTE, 8'h01, 1'b0, 1'b0, '0},
        '{REQ_BYTE, 8'h02, 1'b0, 1'b0, '0},
        '{REQ_BYTE, 8'h04, 1'b0, 1'b0, '0},
        '{REQ_BYTE, 8'h08, 1'b0, 1'b0, '0},
        '{REQ_BYTE, 8'h10, 1'b0, 1'b0, '0},
        '{REQ_BYTE, 8'h20, 1'b0, 1'b0, '0},
        '{REQ_BYTE, 8'h40, 1'b0, 1'b0, '0},
        '{REQ_BYTE, 8'h80, 1'b0, 1'b0, '0},
        '{REQ_BYTE, 8'h7F, 1'b0, 1'b0, '0},
        '{REQ_BYTE, 8'h3C, 1'b0, 1'b0, '0},
        '{REQ_BYTE, 8'hC3, 1'b0, 1'b0, '0},
        '{REQ_BYTE, 8'h7E, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1}},
        '{REQ_BYTE, 8'h7E, 1'b0, 1'b0, '0},
        '{REQ_BYTE, 8'h99, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1}},
        '{REQ_TICK, 8'h00, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1}}
    };

    // Random phases: register setting, beat count, share of colour bytes.
    // Byte-heavy phases keep the queue full; tick-heavy ones feed it ticks,
    // one with a zero and one with the longest latch setting.
    localparam int N_PHASES = 5;
    localparam phase_t PHASES [N_PHASES] = '{
        '{16'd1,     16'd3,     300, 50},
        '{16'd0,     16'd0,     300, 4},
        '{16'd2,     16'd40,    250, 25},
        '{16'd1,     16'hFFFF,  200, 8},
        '{16'hFFFF,  16'd0,     100, 50}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [7:0]  byte_value;
    logic        frame_end;
    logic        out_valid;
    logic        out_stall;
    logic        accepted;
    logic        line_level;
    logic        busy_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rgb_led_one_wire_serializer_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .byte_value (byte_value),
        .frame_end  (frame_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .accepted   (accepted),
        .line_level (line_level),
        .busy_res   (busy_res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ---------------------------------------------------------------
    // Serializer predictor: own copy of registers, packer, queue and
    // line timing, advanced once per accepted input beat.
    // ---------------------------------------------------------------
    logic [DIV_W-1:0]   cfg_slot_div;
    logic [15:0]        cfg_latch;
    logic [15:0]        col_partial;
    logic [1:0]         col_held;
    logic               frame_has_px;
    queue_entry_t       px_fifo [FIFO_DEPTH];
    logic [$clog2(FIFO_DEPTH)-1:0] fifo_rd;
    logic [$clog2(FIFO_DEPTH)-1:0] fifo_wr;
    int unsigned        fifo_fill;
    logic [PIXEL_W-1:0] tx_word;
    int unsigned        tx_bit;
    logic [PHASE_W-1:0] tx_slot;
    logic [DIV_W-1:0]   slot_ticks;
    logic [15:0]        latch_left;
    logic               tx_active;

    led_result_t pending_led_results [$];
    int unsigned beats_sent;
    int unsigned results_seen;
    int unsigned bad_beats;
    int unsigned quiet_cycles;

    function automatic void reset_predictor();
        cfg_slot_div = SLOT_DIVIDER_RST;
        cfg_latch    = LATCH_SLOTS_RST;
        col_partial  = '0;
        col_held     = '0;
        frame_has_px = 1'b0;
        fifo_rd      = '0;
        fifo_wr      = '0;
        fifo_fill    = 0;
        tx_word      = '0;
        tx_bit       = 0;
        tx_slot      = '0;
        slot_ticks   = '0;
        latch_left   = '0;
        tx_active    = 1'b0;
    endfunction

    function automatic void push_entry(queue_entry_t e);
        px_fifo[fifo_wr] = e;
        fifo_wr++;
        fifo_fill++;
    endfunction

    // Level on the wire for the current slot; MSB of the pixel goes first.
    function automatic logic line_now();
        if (!tx_active || tx_bit >= PIX_BITS)
            return 1'b0;
        if (tx_slot < LOW_SLOTS)
            return 1'b0;
        if (tx_slot < HIGH_SLOT_END)
            return 1'b1;
        return tx_word[PIX_BITS-1-tx_bit];
    endfunction

    task automatic tick_line(output logic lvl);
        queue_entry_t     head;
        logic [DIV_W-1:0] div;
        lvl = 1'b0;
        // idle line: the head entry starts within this very tick
        if (!tx_active && latch_left == 0) begin
            if (fifo_fill == 0)
                return;
            head = px_fifo[fifo_rd];
            fifo_rd++;
            fifo_fill--;
            slot_ticks = '0;
            tx_slot    = '0;
            tx_bit     = 0;
            if (head.marker) begin
                latch_left = cfg_latch;
                // zero latch: the marker only eats this tick
                if (latch_left == 0)
                    return;
            end
            else begin
                tx_word   = head.pixel;
                tx_active = 1'b1;
            end
        end
        lvl = line_now();
        div = (cfg_slot_div == 0) ? 16'd1 : cfg_slot_div;
        slot_ticks++;
        if (slot_ticks >= div) begin
            slot_ticks = '0;
            if (tx_active) begin
                tx_slot++;
                if (tx_slot >= SLOTS_PER_BIT) begin
                    tx_slot = '0;
                    tx_bit++;
                    if (tx_bit >= PIX_BITS) begin
                        tx_bit    = 0;
                        tx_active = 1'b0;
                    end
                end
            end
            else if (latch_left > 0) begin
                latch_left--;
            end
        end
    endtask

    // A byte is refused when the queue cannot take the pixel it completes
    // plus the latch marker of a frame it closes.
    task automatic take_byte(input logic [7:0] val, input logic fe, output logic acc);
        logic        completes;
        logic        hasp;
        int unsigned need;
        completes = (col_held >= 2);
        hasp      = frame_has_px || completes;
        need      = (completes ? 1 : 0) + ((fe && hasp) ? 1 : 0);
        acc       = 1'b0;
        if (need > FIFO_DEPTH - fifo_fill)
            return;
        acc = 1'b1;
        if (completes) begin
            push_entry('{marker: 1'b0, pixel: {col_partial, val}});
            frame_has_px = 1'b1;
            col_partial  = '0;
            col_held     = '0;
        end
        else begin
            col_partial = {col_partial[7:0], val};
            col_held++;
        end
        if (fe) begin
            // frame end: partial bytes dropped, marker only after a pixel
            if (hasp)
                push_entry('{marker: 1'b1, pixel: '0});
            col_partial  = '0;
            col_held     = '0;
            frame_has_px = 1'b0;
        end
    endtask

    task automatic predict_led_beat(input req_kind_t kind, input logic [7:0] val,
                                    input logic fe, output led_result_t r);
        r.accepted = 1'b0;
        if (kind == REQ_TICK) begin
            tick_line(r.line);
        end
        else begin
            take_byte(val, fe, r.accepted);
            r.line = line_now();
        end
        r.busy = (fifo_fill > 0) || tx_active || (latch_left > 0);
    endtask

    // ---------------------------------------------------------------
    // Input side: one beat per call, with random idle cycles in front.
    // ---------------------------------------------------------------
    task automatic send_beat(input req_kind_t kind, input logic [7:0] val, input logic fe,
                             input logic typed, input led_result_t want);
        led_result_t r;
        @(negedge clk);
        while (!(beats_sent >= TX_CALM_LO && beats_sent < TX_CALM_HI)
               && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        byte_value <= val;
        frame_end  <= fe;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
        predict_led_beat(kind, val, fe, r);
        pending_led_results.push_back(typed ? want : r);
    endtask

    task automatic random_beat(input int unsigned byte_pct);
        req_kind_t kind;
        logic      fe;
        kind = ($urandom_range(0, 99) < byte_pct) ? REQ_BYTE : REQ_TICK;
        // frame_end is noise on ticks, a frame closer on about 1 byte in 8
        fe = (kind == REQ_BYTE) ? ($urandom_range(0, 7) == 0) : 1'($urandom_range(0, 1));
        send_beat(kind, 8'($urandom_range(0, 255)), fe, 1'b0, '0);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_led_results.size() != 0)
            @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the write lands on the edge with pready.
    task automatic apb_write(input logic sel, input logic [15:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {16'h0000, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (sel == REG_SLOT_DIVIDER)
            cfg_slot_div = value;
        else
            cfg_latch = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Main sequence: reset, directed table, random phases, drain.
    // ---------------------------------------------------------------
    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        req_type   = REQ_TICK;
        byte_value = '0;
        frame_end  = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        beats_sent = 0;
        reset_predictor();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part runs on the reset register values
        for (int i = 0; i < N_ROWS; i++)
            send_beat(DIR_ROWS[i].kind, DIR_ROWS[i].val, DIR_ROWS[i].fe,
                      DIR_ROWS[i].typed, DIR_ROWS[i].want);

        // every phase starts from a drained output: sender pauses first
        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            apb_write(REG_SLOT_DIVIDER, PHASES[p].div);
            apb_write(REG_LATCH_SLOTS, PHASES[p].latch);
            for (int unsigned k = 0; k < PHASES[p].n; k++)
                random_beat(PHASES[p].byte_pct);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (bad_beats == 0 && pending_led_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Output side: random stalls, one long hold-off that backs the
    // block up into its input, and a stretch with no stalls.
    // ---------------------------------------------------------------
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= !(results_seen >= RX_CALM_LO && results_seen < RX_CALM_HI)
                         && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Result checker: every accepted result beat against the oldest prediction.
    initial begin
        results_seen = 0;
        bad_beats    = 0;
    end

    always @(posedge clk) begin
        led_result_t got;
        led_result_t exp_r;
        if (rst_n && out_valid && !out_stall) begin
            got = '{accepted, line_level, busy_res};
            if (pending_led_results.size() == 0) begin
                bad_beats++;
                if (bad_beats <= MAX_REPORTS)
                    $display("result %0d arrived with nothing predicted: %s %b %b %b",
                             results_seen, "acc line busy",
                             got.accepted, got.line, got.busy);
            end
            else begin
                exp_r = pending_led_results.pop_front();
                if (got !== exp_r) begin
                    bad_beats++;
                    if (bad_beats <= MAX_REPORTS)
                        $display({"result %0d: acc exp %b got %b, ",
                                  "line exp %b got %b, busy exp %b got %b"},
                                 results_seen, exp_r.accepted, got.accepted,
                                 exp_r.line, got.line, exp_r.busy, got.busy);
                end
            end
            results_seen++;
        end
    end

    // Watchdog: too long with no beat taken on either channel.
    initial quiet_cycles = 0;

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STUCK_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

endmodule
`default_nettype wire
